/* rtl/lsq_pkg.sv */
// Shared types, widths, codes and helpers for the least-squares line fit block
`timescale 1ns / 1ps
package lsq_pkg;

	// Capacity and field widths
	localparam int MAX_SAMPLES = 64;
	localparam int X_W         = 20;
	localparam int Y_W         = 16;
	localparam int CNT_W       = 7;
	localparam int SX_W        = 26;
	localparam int SY_W        = 22;
	localparam int SX2_W       = 45;
	localparam int SXY_W       = 42;
	localparam int SY2_W       = 38;
	localparam int FIT_W       = 48;
	localparam int R2_W        = 17;

	// Fit arithmetic widths
	localparam int SXX_W   = 51;
	localparam int SYY_W   = 45;
	localparam int CXY_W   = 49;
	localparam int TMP_W   = 52;
	localparam int INUM_W  = 67;
	localparam int OP_W    = 96;
	localparam int MPL_W   = 48;
	localparam int MCD_W   = 51;
	localparam int PROD_W  = MPL_W + MCD_W;
	localparam int DNUM_W  = 83;
	localparam int QUO_W   = 49;
	localparam int REM_W   = 98;
	localparam int STEP_W  = 7;
	localparam int R2_STEPS = 17;

	// Request queue between front and back
	localparam int QUEUE_DEPTH = 2;
	localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

	localparam logic [FIT_W-1:0] POS_LIM = {1'b0, {(FIT_W-1){1'b1}}};
	localparam logic [FIT_W-1:0] NEG_LIM = {1'b1, {(FIT_W-1){1'b0}}};
	localparam logic [R2_W-1:0]  R2_ONE  = {1'b1, {(R2_W-1){1'b0}}};

	typedef enum logic [1:0] {
		STATUS_OK      = 2'd0,
		STATUS_X_FLAT  = 2'd1,
		STATUS_Y_FLAT  = 2'd2,
		STATUS_DROPPED = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		OP_MUL  = 2'd0,
		OP_DIV  = 2'd1,
		OP_FRAC = 2'd2
	} arith_op_t;

	typedef enum logic [4:0] {
		BK_IDLE,
		BK_NX2,
		BK_SX2,
		BK_NY2,
		BK_SY2,
		BK_NXY,
		BK_SXSY,
		BK_CHECK,
		BK_MEAN,
		BK_SLOPE,
		BK_A,
		BK_B,
		BK_ICPT,
		BK_P,
		BK_DEN,
		BK_R2,
		BK_EMIT
	} bk_state_t;

	// Closed set of sums handed from front to back
	typedef struct packed {
		logic [CNT_W-1:0] n;
		logic [SX_W-1:0]  sx;
		logic [SY_W-1:0]  sy;
		logic [SX2_W-1:0] sx2;
		logic [SXY_W-1:0] sxy;
		logic [SY2_W-1:0] sy2;
		logic             drop;
	} snap_t;

	typedef struct packed {
		logic            start;
		arith_op_t       op;
		logic [OP_W-1:0] opa;
		logic [OP_W-1:0] opb;
	} arith_req_t;

	typedef struct packed {
		logic              done;
		logic [PROD_W-1:0] prod;
		logic [QUO_W-1:0]  quo;
		logic              ovf;
		logic [R2_W-1:0]   frac;
	} arith_rsp_t;

	// Clamp a quotient magnitude with its sign to 48-bit two's complement
	function automatic logic [FIT_W-1:0] sat48(input logic [QUO_W-1:0] q, input logic ovf,
			input logic neg);
		logic [QUO_W-1:0] lim;
		lim = {1'b0, NEG_LIM};
		if (neg) begin
			if (ovf || q >= lim) begin
				return NEG_LIM;
			end
			return FIT_W'(~q + QUO_W'(1));
		end
		if (ovf || q > {1'b0, POS_LIM}) begin
			return POS_LIM;
		end
		return q[FIT_W-1:0];
	endfunction

endpackage

/* rtl/lsq_front.sv */
// Front part: take sample pairs, form products and accumulate the running sums
`timescale 1ns / 1ps
module lsq_front (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [lsq_pkg::X_W-1:0]     x_sample,
	input  logic [lsq_pkg::Y_W-1:0]     y_sample,
	input  logic                        last,
	output logic                        push,
	output lsq_pkg::snap_t              push_data,
	input  logic                        q_full
);

	logic                                v1_q, v2_q;
	logic signed [lsq_pkg::X_W-1:0]      x_s1, x_s2;
	logic [lsq_pkg::Y_W-1:0]             y_s1, y_s2;
	logic                                last_s1, last_s2;
	logic signed [2*lsq_pkg::X_W-1:0]    xx_full;
	logic signed [lsq_pkg::X_W+lsq_pkg::Y_W:0] xy_full;
	logic [2*lsq_pkg::X_W-2:0]           xx_s2;
	logic signed [lsq_pkg::X_W+lsq_pkg::Y_W:0] xy_s2;
	logic [2*lsq_pkg::Y_W-1:0]           yy_s2;

	logic [lsq_pkg::CNT_W-1:0]           cnt_q, cnt_n;
	logic [lsq_pkg::SX_W-1:0]            sx_q, sx_n;
	logic [lsq_pkg::SY_W-1:0]            sy_q, sy_n;
	logic [lsq_pkg::SX2_W-1:0]           sx2_q, sx2_n;
	logic [lsq_pkg::SXY_W-1:0]           sxy_q, sxy_n;
	logic [lsq_pkg::SY2_W-1:0]           sy2_q, sy2_n;
	logic                                drop_q, drop_n;
	logic                                keep, fire;

	// One pair in flight at a time
	assign in_ready = !v1_q && !v2_q;

	// Products of the registered pair
	assign xx_full = x_s1 * x_s1;
	assign xy_full = x_s1 * $signed({1'b0, y_s1});

	// Hold the pair while the accumulate stage waits for queue room on a last pair
	assign fire = v2_q && (!last_s2 || !q_full);
	assign push = v2_q && last_s2 && !q_full;

	// Next sums with this pair added, unless capacity is full
	always_comb begin
		keep   = cnt_q < lsq_pkg::CNT_W'(lsq_pkg::MAX_SAMPLES);
		cnt_n  = cnt_q;
		sx_n   = sx_q;
		sy_n   = sy_q;
		sx2_n  = sx2_q;
		sxy_n  = sxy_q;
		sy2_n  = sy2_q;
		drop_n = drop_q | !keep;
		if (keep) begin
			cnt_n = cnt_q + lsq_pkg::CNT_W'(1);
			sx_n  = sx_q + lsq_pkg::SX_W'(x_s2);
			sy_n  = sy_q + lsq_pkg::SY_W'(y_s2);
			sx2_n = sx2_q + lsq_pkg::SX2_W'(xx_s2);
			sxy_n = sxy_q + lsq_pkg::SXY_W'(xy_s2);
			sy2_n = sy2_q + lsq_pkg::SY2_W'(yy_s2);
		end
		push_data.n    = cnt_n;
		push_data.sx   = sx_n;
		push_data.sy   = sy_n;
		push_data.sx2  = sx2_n;
		push_data.sxy  = sxy_n;
		push_data.sy2  = sy2_n;
		push_data.drop = drop_n;
	end

	// Stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q <= 1'b0;
			v2_q <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				v1_q <= 1'b1;
			end else if (v1_q) begin
				v1_q <= 1'b0;
			end
			if (v1_q) begin
				v2_q <= 1'b1;
			end else if (fire) begin
				v2_q <= 1'b0;
			end
		end
	end

	// Pipeline payload
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			x_s1    <= x_sample;
			y_s1    <= y_sample;
			last_s1 <= last;
		end
		if (v1_q) begin
			x_s2    <= x_s1;
			y_s2    <= y_s1;
			last_s2 <= last_s1;
			xx_s2   <= xx_full[2*lsq_pkg::X_W-2:0];
			xy_s2   <= xy_full;
			yy_s2   <= y_s1 * y_s1;
		end
	end

	// Accumulate, and clear once the set is handed over
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			sx_q   <= '0;
			sy_q   <= '0;
			sx2_q  <= '0;
			sxy_q  <= '0;
			sy2_q  <= '0;
			drop_q <= 1'b0;
		end else if (fire) begin
			if (last_s2) begin
				cnt_q  <= '0;
				sx_q   <= '0;
				sy_q   <= '0;
				sx2_q  <= '0;
				sxy_q  <= '0;
				sy2_q  <= '0;
				drop_q <= 1'b0;
			end else begin
				cnt_q  <= cnt_n;
				sx_q   <= sx_n;
				sy_q   <= sy_n;
				sx2_q  <= sx2_n;
				sxy_q  <= sxy_n;
				sy2_q  <= sy2_n;
				drop_q <= drop_n;
			end
		end
	end

endmodule

/* rtl/lsq_queue.sv */
// Two-entry queue of closed sum sets between front and back
`timescale 1ns / 1ps
module lsq_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  lsq_pkg::snap_t push_data,
	output logic           full,
	input  logic           pop,
	output lsq_pkg::snap_t pop_data,
	output logic           empty
);

	lsq_pkg::snap_t                mem_q [lsq_pkg::QUEUE_DEPTH];
	logic [lsq_pkg::QUEUE_AW-1:0]  wr_q, rd_q;
	logic [lsq_pkg::QUEUE_AW:0]    cnt_q;
	logic                          do_push, do_pop;

	assign full     = cnt_q == (lsq_pkg::QUEUE_AW+1)'(lsq_pkg::QUEUE_DEPTH);
	assign empty    = cnt_q == '0;
	assign do_push  = push && !full;
	assign do_pop   = pop && !empty;
	assign pop_data = mem_q[rd_q];

	// Store entries
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= push_data;
		end
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= wr_q + lsq_pkg::QUEUE_AW'(1);
			end
			if (do_pop) begin
				rd_q <= rd_q + lsq_pkg::QUEUE_AW'(1);
			end
			case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + (lsq_pkg::QUEUE_AW+1)'(1);
				2'b01:   cnt_q <= cnt_q - (lsq_pkg::QUEUE_AW+1)'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

/* rtl/lsq_arith.sv */
// Shared serial unit: shift-add multiply, long divide and fractional ratio
`timescale 1ns / 1ps
module lsq_arith (
	input  logic                clk,
	input  logic                arst_n,
	input  lsq_pkg::arith_req_t req,
	output lsq_pkg::arith_rsp_t rsp
);

	logic                         busy_q, done_q, ovf_q;
	lsq_pkg::arith_op_t           op_q;
	logic [lsq_pkg::STEP_W-1:0]   cnt_q;
	logic [lsq_pkg::MPL_W-1:0]    mpl_q;
	logic [lsq_pkg::PROD_W-1:0]   mcd_q, acc_q;
	logic [lsq_pkg::DNUM_W-1:0]   num_q;
	logic [lsq_pkg::OP_W-1:0]     den_q;
	logic [lsq_pkg::REM_W-1:0]    rem_q;
	logic [lsq_pkg::QUO_W-1:0]    quo_q;
	logic [lsq_pkg::R2_W-1:0]     frac_q;
	logic [lsq_pkg::MCD_W:0]      dtry, dsub;
	logic                         dge, fge;
	logic [lsq_pkg::REM_W-1:0]    fsub;

	// Divide step: bring down one numerator bit, subtract when it fits
	assign dtry = {rem_q[lsq_pkg::MCD_W-1:0], num_q[lsq_pkg::DNUM_W-1]};
	assign dge  = dtry >= {1'b0, den_q[lsq_pkg::MCD_W-1:0]};
	assign dsub = dtry - {1'b0, den_q[lsq_pkg::MCD_W-1:0]};

	// Ratio step: compare, subtract, then double the remainder
	assign fge  = rem_q >= lsq_pkg::REM_W'(den_q);
	assign fsub = rem_q - lsq_pkg::REM_W'(den_q);

	assign rsp.done = done_q;
	assign rsp.prod = acc_q;
	assign rsp.quo  = quo_q;
	assign rsp.ovf  = ovf_q;
	assign rsp.frac = (frac_q > lsq_pkg::R2_ONE) ? lsq_pkg::R2_ONE : frac_q;

	// Control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			op_q   <= lsq_pkg::OP_MUL;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (!busy_q) begin
				if (req.start) begin
					busy_q <= 1'b1;
					op_q   <= req.op;
					cnt_q  <= (req.op == lsq_pkg::OP_DIV) ? lsq_pkg::STEP_W'(lsq_pkg::DNUM_W)
						: lsq_pkg::STEP_W'(lsq_pkg::R2_STEPS);
				end
			end else begin
				case (op_q)
					lsq_pkg::OP_MUL: begin
						if (mpl_q == '0) begin
							busy_q <= 1'b0;
							done_q <= 1'b1;
						end
					end
					default: begin
						if (cnt_q == '0) begin
							busy_q <= 1'b0;
							done_q <= 1'b1;
						end else begin
							cnt_q <= cnt_q - lsq_pkg::STEP_W'(1);
						end
					end
				endcase
			end
		end
	end

	// Datapath
	always_ff @(posedge clk) begin
		if (!busy_q) begin
			if (req.start) begin
				mpl_q  <= req.opa[lsq_pkg::MPL_W-1:0];
				mcd_q  <= lsq_pkg::PROD_W'(req.opb[lsq_pkg::MCD_W-1:0]);
				acc_q  <= '0;
				num_q  <= req.opa[lsq_pkg::DNUM_W-1:0];
				den_q  <= req.opb;
				rem_q  <= (req.op == lsq_pkg::OP_FRAC) ? lsq_pkg::REM_W'(req.opa) : '0;
				quo_q  <= '0;
				ovf_q  <= 1'b0;
				frac_q <= '0;
			end
		end else begin
			case (op_q)
				lsq_pkg::OP_MUL: begin
					if (mpl_q != '0) begin
						if (mpl_q[0]) begin
							acc_q <= acc_q + mcd_q;
						end
						mpl_q <= mpl_q >> 1;
						mcd_q <= mcd_q << 1;
					end
				end
				lsq_pkg::OP_DIV: begin
					if (cnt_q != '0) begin
						rem_q <= lsq_pkg::REM_W'(dge ? dsub : dtry);
						num_q <= num_q << 1;
						quo_q <= {quo_q[lsq_pkg::QUO_W-2:0], dge};
						ovf_q <= ovf_q | quo_q[lsq_pkg::QUO_W-1];
					end
				end
				lsq_pkg::OP_FRAC: begin
					if (cnt_q != '0) begin
						rem_q  <= (fge ? fsub : rem_q) << 1;
						frac_q <= {frac_q[lsq_pkg::R2_W-2:0], fge};
					end
				end
				default: begin
					acc_q <= acc_q;
				end
			endcase
		end
	end

endmodule

/* rtl/lsq_back.sv */
// Back part: sequence the fit of one closed set and register the result
`timescale 1ns / 1ps
module lsq_back (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       q_empty,
	input  lsq_pkg::snap_t             pop_data,
	output logic                       pop,
	output lsq_pkg::arith_req_t        req,
	input  lsq_pkg::arith_rsp_t        rsp,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [lsq_pkg::FIT_W-1:0]  intercept,
	output logic [lsq_pkg::FIT_W-1:0]  slope,
	output logic [lsq_pkg::R2_W-1:0]   r_squared,
	output logic [1:0]                 status,
	output logic [lsq_pkg::CNT_W-1:0]  sample_count
);

	lsq_pkg::bk_state_t              state_q, state_n;
	lsq_pkg::snap_t                  snap_q;
	logic                            issued_q, out_valid_q, op_state, emit;
	logic [lsq_pkg::TMP_W-1:0]       t_q, prod_s, prod_sx;
	logic [lsq_pkg::SXX_W-1:0]       sxx_q;
	logic [lsq_pkg::SYY_W-1:0]       syy_q;
	logic [lsq_pkg::CXY_W-1:0]       sxy_q, sxy_tmp;
	logic [lsq_pkg::MPL_W-1:0]       sxy_mag;
	logic [lsq_pkg::SX_W-1:0]        sx_mag;
	logic [lsq_pkg::SXY_W-1:0]       sxys_mag;
	logic [lsq_pkg::INUM_W-1:0]      a_q, b_v, num_q;
	logic                            ineg_q;
	logic [lsq_pkg::OP_W-1:0]        p_q, den_q;
	logic [lsq_pkg::FIT_W-1:0]       slope_q, icpt_q, out_slope_q, out_icpt_q;
	logic [lsq_pkg::R2_W-1:0]        r2_q, out_r2_q;
	lsq_pkg::status_t                status_c, out_status_q;
	logic [lsq_pkg::CNT_W-1:0]       out_n_q;

	// Magnitudes of the signed sums
	assign sx_mag   = snap_q.sx[lsq_pkg::SX_W-1] ? (~snap_q.sx + lsq_pkg::SX_W'(1)) : snap_q.sx;
	assign sxys_mag = snap_q.sxy[lsq_pkg::SXY_W-1] ? (~snap_q.sxy + lsq_pkg::SXY_W'(1))
		: snap_q.sxy;
	assign sxy_tmp  = sxy_q[lsq_pkg::CXY_W-1] ? (~sxy_q + lsq_pkg::CXY_W'(1)) : sxy_q;
	assign sxy_mag  = sxy_tmp[lsq_pkg::MPL_W-1:0];
	assign prod_s   = rsp.prod[lsq_pkg::TMP_W-1:0];
	assign prod_sx  = snap_q.sx[lsq_pkg::SX_W-1] ? (lsq_pkg::TMP_W'(0) - prod_s) : prod_s;
	assign b_v      = rsp.prod[lsq_pkg::INUM_W-1:0];

	// Status priority: flat x, then flat y, then drops
	always_comb begin
		if (sxx_q == '0) begin
			status_c = lsq_pkg::STATUS_X_FLAT;
		end else if (syy_q == '0) begin
			status_c = lsq_pkg::STATUS_Y_FLAT;
		end else if (snap_q.drop) begin
			status_c = lsq_pkg::STATUS_DROPPED;
		end else begin
			status_c = lsq_pkg::STATUS_OK;
		end
	end

	// Next state
	always_comb begin
		state_n = state_q;
		case (state_q)
			lsq_pkg::BK_IDLE:  if (!q_empty) state_n = lsq_pkg::BK_NX2;
			lsq_pkg::BK_NX2:   if (rsp.done) state_n = lsq_pkg::BK_SX2;
			lsq_pkg::BK_SX2:   if (rsp.done) state_n = lsq_pkg::BK_NY2;
			lsq_pkg::BK_NY2:   if (rsp.done) state_n = lsq_pkg::BK_SY2;
			lsq_pkg::BK_SY2:   if (rsp.done) state_n = lsq_pkg::BK_NXY;
			lsq_pkg::BK_NXY:   if (rsp.done) state_n = lsq_pkg::BK_SXSY;
			lsq_pkg::BK_SXSY:  if (rsp.done) state_n = lsq_pkg::BK_CHECK;
			lsq_pkg::BK_CHECK: begin
				if (sxx_q != '0) begin
					state_n = lsq_pkg::BK_SLOPE;
				end else if (snap_q.n != '0) begin
					state_n = lsq_pkg::BK_MEAN;
				end else begin
					state_n = lsq_pkg::BK_EMIT;
				end
			end
			lsq_pkg::BK_MEAN:  if (rsp.done) state_n = lsq_pkg::BK_EMIT;
			lsq_pkg::BK_SLOPE: if (rsp.done) state_n = lsq_pkg::BK_A;
			lsq_pkg::BK_A:     if (rsp.done) state_n = lsq_pkg::BK_B;
			lsq_pkg::BK_B:     if (rsp.done) state_n = lsq_pkg::BK_ICPT;
			lsq_pkg::BK_ICPT: begin
				if (rsp.done) begin
					state_n = (syy_q == '0) ? lsq_pkg::BK_EMIT : lsq_pkg::BK_P;
				end
			end
			lsq_pkg::BK_P:     if (rsp.done) state_n = lsq_pkg::BK_DEN;
			lsq_pkg::BK_DEN:   if (rsp.done) state_n = lsq_pkg::BK_R2;
			lsq_pkg::BK_R2:    if (rsp.done) state_n = lsq_pkg::BK_EMIT;
			lsq_pkg::BK_EMIT:  if (emit) state_n = lsq_pkg::BK_IDLE;
			default:           state_n = lsq_pkg::BK_IDLE;
		endcase
	end

	// Outputs: queue pop and operand selection for the serial unit
	always_comb begin
		pop      = 1'b0;
		op_state = 1'b1;
		emit     = 1'b0;
		req.op   = lsq_pkg::OP_MUL;
		req.opa  = '0;
		req.opb  = '0;
		case (state_q)
			lsq_pkg::BK_IDLE: begin
				op_state = 1'b0;
				pop      = !q_empty;
			end
			lsq_pkg::BK_NX2: begin
				req.opa = lsq_pkg::OP_W'(snap_q.n);
				req.opb = lsq_pkg::OP_W'(snap_q.sx2);
			end
			lsq_pkg::BK_SX2: begin
				req.opa = lsq_pkg::OP_W'(sx_mag);
				req.opb = lsq_pkg::OP_W'(sx_mag);
			end
			lsq_pkg::BK_NY2: begin
				req.opa = lsq_pkg::OP_W'(snap_q.n);
				req.opb = lsq_pkg::OP_W'(snap_q.sy2);
			end
			lsq_pkg::BK_SY2: begin
				req.opa = lsq_pkg::OP_W'(snap_q.sy);
				req.opb = lsq_pkg::OP_W'(snap_q.sy);
			end
			lsq_pkg::BK_NXY: begin
				req.opa = lsq_pkg::OP_W'(snap_q.n);
				req.opb = lsq_pkg::OP_W'(sxys_mag);
			end
			lsq_pkg::BK_SXSY: begin
				req.opa = lsq_pkg::OP_W'(snap_q.sy);
				req.opb = lsq_pkg::OP_W'(sx_mag);
			end
			lsq_pkg::BK_MEAN: begin
				req.op  = lsq_pkg::OP_DIV;
				req.opa = lsq_pkg::OP_W'({snap_q.sy, 16'd0});
				req.opb = lsq_pkg::OP_W'(snap_q.n);
			end
			lsq_pkg::BK_SLOPE: begin
				req.op  = lsq_pkg::OP_DIV;
				req.opa = lsq_pkg::OP_W'({sxy_mag, 24'd0});
				req.opb = lsq_pkg::OP_W'(sxx_q);
			end
			lsq_pkg::BK_A: begin
				req.opa = lsq_pkg::OP_W'(snap_q.sy);
				req.opb = lsq_pkg::OP_W'(snap_q.sx2);
			end
			lsq_pkg::BK_B: begin
				req.opa = lsq_pkg::OP_W'(sx_mag);
				req.opb = lsq_pkg::OP_W'(sxys_mag);
			end
			lsq_pkg::BK_ICPT: begin
				req.op  = lsq_pkg::OP_DIV;
				req.opa = lsq_pkg::OP_W'({num_q, 16'd0});
				req.opb = lsq_pkg::OP_W'(sxx_q);
			end
			lsq_pkg::BK_P: begin
				req.opa = lsq_pkg::OP_W'(sxy_mag);
				req.opb = lsq_pkg::OP_W'(sxy_mag);
			end
			lsq_pkg::BK_DEN: begin
				req.opa = lsq_pkg::OP_W'(syy_q);
				req.opb = lsq_pkg::OP_W'(sxx_q);
			end
			lsq_pkg::BK_R2: begin
				req.op  = lsq_pkg::OP_FRAC;
				req.opa = p_q;
				req.opb = den_q;
			end
			lsq_pkg::BK_CHECK: begin
				op_state = 1'b0;
			end
			lsq_pkg::BK_EMIT: begin
				op_state = 1'b0;
				emit     = !out_valid_q || out_ready;
			end
			default: begin
				op_state = 1'b0;
			end
		endcase
		req.start = op_state && !issued_q;
	end

	// State and request tracking
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= lsq_pkg::BK_IDLE;
			issued_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if (req.start) begin
				issued_q <= 1'b1;
			end else if (rsp.done) begin
				issued_q <= 1'b0;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Capture partial results as each operation finishes
	always_ff @(posedge clk) begin
		if (pop) begin
			snap_q  <= pop_data;
			slope_q <= '0;
			icpt_q  <= '0;
			r2_q    <= '0;
		end
		if (rsp.done) begin
			case (state_q)
				lsq_pkg::BK_NX2:   t_q <= prod_s;
				lsq_pkg::BK_SX2:   sxx_q <= t_q[lsq_pkg::SXX_W-1:0] - prod_s[lsq_pkg::SXX_W-1:0];
				lsq_pkg::BK_NY2:   t_q <= prod_s;
				lsq_pkg::BK_SY2:   syy_q <= t_q[lsq_pkg::SYY_W-1:0] - prod_s[lsq_pkg::SYY_W-1:0];
				lsq_pkg::BK_NXY: begin
					t_q <= snap_q.sxy[lsq_pkg::SXY_W-1] ? (lsq_pkg::TMP_W'(0) - prod_s) : prod_s;
				end
				lsq_pkg::BK_SXSY:  sxy_q <= lsq_pkg::CXY_W'(t_q - prod_sx);
				lsq_pkg::BK_MEAN:  icpt_q <= rsp.quo[lsq_pkg::FIT_W-1:0];
				lsq_pkg::BK_SLOPE: begin
					slope_q <= lsq_pkg::sat48(rsp.quo, rsp.ovf, sxy_q[lsq_pkg::CXY_W-1]);
				end
				lsq_pkg::BK_A:     a_q <= rsp.prod[lsq_pkg::INUM_W-1:0];
				lsq_pkg::BK_B: begin
					if (snap_q.sx[lsq_pkg::SX_W-1] != snap_q.sxy[lsq_pkg::SXY_W-1]) begin
						num_q  <= a_q + b_v;
						ineg_q <= 1'b0;
					end else if (a_q >= b_v) begin
						num_q  <= a_q - b_v;
						ineg_q <= 1'b0;
					end else begin
						num_q  <= b_v - a_q;
						ineg_q <= 1'b1;
					end
				end
				lsq_pkg::BK_ICPT:  icpt_q <= lsq_pkg::sat48(rsp.quo, rsp.ovf, ineg_q);
				lsq_pkg::BK_P:     p_q <= rsp.prod[lsq_pkg::OP_W-1:0];
				lsq_pkg::BK_DEN:   den_q <= rsp.prod[lsq_pkg::OP_W-1:0];
				lsq_pkg::BK_R2:    r2_q <= rsp.frac;
				default:           t_q <= t_q;
			endcase
		end
		// Output register
		if (emit) begin
			out_icpt_q   <= icpt_q;
			out_slope_q  <= slope_q;
			out_r2_q     <= r2_q;
			out_status_q <= status_c;
			out_n_q      <= snap_q.n;
		end
	end

	assign out_valid    = out_valid_q;
	assign intercept    = out_icpt_q;
	assign slope        = out_slope_q;
	assign r_squared    = out_r2_q;
	assign status       = out_status_q;
	assign sample_count = out_n_q;

	// r squared never exceeds one
	a_r2_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> out_r2_q <= lsq_pkg::R2_ONE)
		else $error("r squared above one");

	// Flat x gives a zero slope and a zero r squared
	a_xflat: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_status_q == lsq_pkg::STATUS_X_FLAT
		|-> out_slope_q == '0 && out_r2_q == '0)
		else $error("flat x result carries a slope or r squared");

	// Every completion answers a request that is outstanding
	a_done_issued: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.done |-> issued_q)
		else $error("serial unit finished without a request");

	// A set is taken from the queue only while idle
	a_pop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> state_q == lsq_pkg::BK_NX2)
		else $error("queue pop did not start a fit");

endmodule

/* rtl/least_squares_line_fit_with_r_squared_core.sv */
// A pair passes the front through the product and accumulate stages, and a new pair is taken only once
// both stages are empty. A set closed by last is fitted by the back in a sequence of serial operations on the
// one-bit-per-cycle shift-add multiplier (ten products) and the 83-step long divider.
// The two-entry queue lets the front keep accumulating the next set during a fit.
// Reset (arst_n low) clears all sums, counts, the queue and the output valid at once.
`timescale 1ns / 1ps
module least_squares_line_fit_with_r_squared_core (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [lsq_pkg::X_W-1:0]    x_sample,
	input  logic [lsq_pkg::Y_W-1:0]    y_sample,
	input  logic                       last,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [lsq_pkg::FIT_W-1:0]  intercept,
	output logic [lsq_pkg::FIT_W-1:0]  slope,
	output logic [lsq_pkg::R2_W-1:0]   r_squared,
	output logic [1:0]                 status,
	output logic [lsq_pkg::CNT_W-1:0]  sample_count
);

	logic                push, q_full, q_empty, pop;
	lsq_pkg::snap_t      push_data, pop_data;
	lsq_pkg::arith_req_t req;
	lsq_pkg::arith_rsp_t rsp;

	// Accumulate pairs
	lsq_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.x_sample  (x_sample),
		.y_sample  (y_sample),
		.last      (last),
		.push      (push),
		.push_data (push_data),
		.q_full    (q_full)
	);

	// Buffer closed sets
	lsq_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (q_full),
		.pop       (pop),
		.pop_data  (pop_data),
		.empty     (q_empty)
	);

	// Shared serial arithmetic
	lsq_arith u_arith (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	// Fit sequencer and result register
	lsq_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_empty      (q_empty),
		.pop_data     (pop_data),
		.pop          (pop),
		.req          (req),
		.rsp          (rsp),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.intercept    (intercept),
		.slope        (slope),
		.r_squared    (r_squared),
		.status       (status),
		.sample_count (sample_count)
	);

endmodule

/* bench/least_squares_line_fit_with_r_squared_core_test.sv */
// Self-checking bench for the least-squares line fit core: predicted fits versus DUT results
`timescale 1ns / 1ps
module least_squares_line_fit_with_r_squared_core_test;

	typedef logic signed [127:0] wide_t;

	typedef enum int {
		SHAPE_NOISE,
		SHAPE_LINE,
		SHAPE_FLAT_Y,
		SHAPE_FLAT_X
	} shape_t;

	typedef struct {
		logic [lsq_pkg::FIT_W-1:0] intercept;
		logic [lsq_pkg::FIT_W-1:0] slope;
		logic [lsq_pkg::R2_W-1:0]  r_squared;
		lsq_pkg::status_t          status;
		logic [lsq_pkg::CNT_W-1:0] sample_count;
	} fit_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [lsq_pkg::X_W-1:0] x_sample = '0;
	logic [lsq_pkg::Y_W-1:0] y_sample = '0;
	logic last = 1'b0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [lsq_pkg::FIT_W-1:0] intercept;
	logic [lsq_pkg::FIT_W-1:0] slope;
	logic [lsq_pkg::R2_W-1:0] r_squared;
	logic [1:0] status;
	logic [lsq_pkg::CNT_W-1:0] sample_count;

	// Running sums of the open set, mirrored from the accepted requests
	int     pair_n;
	longint acc_x, acc_y, acc_x2, acc_xy, acc_y2;
	bit     dropped;

	fit_t   pending_fits[$];
	int     fail_count = 0;
	int     sent_pairs = 0;
	int     fits_checked = 0;
	int     send_idle_pct = 0;
	int     recv_stall_pct = 0;
	int     hold_cycles = 0;

	least_squares_line_fit_with_r_squared_core u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.x_sample(x_sample), .y_sample(y_sample), .last(last),
		.out_valid(out_valid), .out_ready(out_ready),
		.intercept(intercept), .slope(slope), .r_squared(r_squared),
		.status(status), .sample_count(sample_count)
	);

	always #5 clk = ~clk;

	// Clamp a quotient magnitude with its sign to 48-bit two's complement
	function automatic logic [lsq_pkg::FIT_W-1:0] clamp_quotient(input wide_t num,
			input wide_t d, input bit neg);
		wide_t q;
		q = num / d;
		if (neg) begin
			if (q >= (wide_t'(1) <<< 47)) begin
				return lsq_pkg::NEG_LIM;
			end
			return lsq_pkg::FIT_W'(-q);
		end
		if (q > (wide_t'(1) <<< 47) - 1) begin
			return lsq_pkg::POS_LIM;
		end
		return lsq_pkg::FIT_W'(q);
	endfunction

	// Add one pair to the sums; on a closing pair, queue the expected fit and clear
	task automatic accumulate_pair(input logic [lsq_pkg::X_W-1:0] xv,
			input logic [lsq_pkg::Y_W-1:0] yv, input bit lst);
		longint xs, ys;
		wide_t n, sxx, syy, sxy, num, den, r2;
		fit_t fit;
		xs = longint'($signed(xv));
		ys = longint'(yv);
		if (pair_n < lsq_pkg::MAX_SAMPLES) begin
			pair_n++;
			acc_x += xs;
			acc_y += ys;
			acc_x2 += xs * xs;
			acc_xy += xs * ys;
			acc_y2 += ys * ys;
		end else begin
			dropped = 1'b1;
		end
		if (!lst) begin
			return;
		end
		n = pair_n;
		sxx = n * wide_t'(acc_x2) - wide_t'(acc_x) * wide_t'(acc_x);
		syy = n * wide_t'(acc_y2) - wide_t'(acc_y) * wide_t'(acc_y);
		sxy = n * wide_t'(acc_xy) - wide_t'(acc_x) * wide_t'(acc_y);
		fit.slope = '0;
		fit.intercept = '0;
		fit.r_squared = '0;
		fit.sample_count = lsq_pkg::CNT_W'(pair_n);
		if (sxx == 0) begin
			fit.status = lsq_pkg::STATUS_X_FLAT;
			if (pair_n != 0) begin
				fit.intercept = lsq_pkg::FIT_W'((acc_y <<< 16) / pair_n);
			end
		end else begin
			fit.slope = clamp_quotient((sxy < 0 ? -sxy : sxy) <<< 24, sxx, sxy < 0);
			num = wide_t'(acc_y) * wide_t'(acc_x2) - wide_t'(acc_x) * wide_t'(acc_xy);
			fit.intercept = clamp_quotient((num < 0 ? -num : num) <<< 16, sxx, num < 0);
			if (syy == 0) begin
				fit.status = lsq_pkg::STATUS_Y_FLAT;
			end else begin
				fit.status = dropped ? lsq_pkg::STATUS_DROPPED : lsq_pkg::STATUS_OK;
				den = sxx * syy;
				r2 = ((sxy * sxy) <<< 16) / den;
				fit.r_squared = (r2 > 65536) ? lsq_pkg::R2_ONE : lsq_pkg::R2_W'(r2);
			end
		end
		pending_fits.push_back(fit);
		pair_n = 0;
		acc_x = 0;
		acc_y = 0;
		acc_x2 = 0;
		acc_xy = 0;
		acc_y2 = 0;
		dropped = 1'b0;
	endtask

	// Offer one request after a random gap, hold it until accepted, then drop valid
	task automatic send_pair(input logic [lsq_pkg::X_W-1:0] xv,
			input logic [lsq_pkg::Y_W-1:0] yv, input bit lst);
		int gap;
		gap = 0;
		while (gap < 40 && $urandom_range(99) < send_idle_pct) begin
			gap++;
		end
		repeat (gap) @(negedge clk);
		@(negedge clk);
		in_valid = 1'b1;
		x_sample = xv;
		y_sample = yv;
		last = lst;
		do @(posedge clk); while (!in_ready);
		accumulate_pair(xv, yv, lst);
		sent_pairs++;
		@(negedge clk);
		in_valid = 1'b0;
	endtask

	task automatic drain_fits();
		@(negedge clk);
		in_valid = 1'b0;
		while (pending_fits.size() != 0) @(negedge clk);
	endtask

	// Send one set of the given shape: noise, line plus noise, flat y or flat x
	task automatic send_set(input int len, input shape_t shape);
		int i, x0, xs, a, b, yi;
		x0 = $urandom_range(1048575) - 524288;
		xs = 1 << $urandom_range(12);
		a = $urandom_range(65535);
		b = $urandom_range(64) - 32;
		yi = $urandom_range(65535);
		for (i = 0; i < len; i++) begin
			case (shape)
				SHAPE_NOISE: begin
					send_pair(lsq_pkg::X_W'($urandom), lsq_pkg::Y_W'($urandom),
						i == len - 1);
				end
				SHAPE_LINE: begin
					int xv, yv;
					xv = int'($urandom_range(2 * xs)) - xs;
					yv = a + (b * xv) / 16 + int'($urandom_range(8)) - 4;
					yv = yv < 0 ? 0 : (yv > 65535 ? 65535 : yv);
					send_pair(lsq_pkg::X_W'(xv), lsq_pkg::Y_W'(yv), i == len - 1);
				end
				SHAPE_FLAT_Y: begin
					send_pair(lsq_pkg::X_W'($urandom), lsq_pkg::Y_W'(yi), i == len - 1);
				end
				default: begin
					send_pair(lsq_pkg::X_W'(x0), lsq_pkg::Y_W'($urandom), i == len - 1);
				end
			endcase
		end
	endtask

	// Extremes, perfect lines, flat data, single pair, saturation
	task automatic test_directed();
		send_pair(20'h80000, 16'd0, 1'b0);
		send_pair(20'h7FFFF, 16'hFFFF, 1'b1);
		send_pair(20'h7FFFF, 16'd0, 1'b0);
		send_pair(20'h7FFFE, 16'hFFFF, 1'b1);
		send_pair(20'h80000, 16'd0, 1'b0);
		send_pair(20'h80001, 16'hFFFF, 1'b1);
		send_pair(20'd100, 16'd5, 1'b1);
		send_pair(20'd0, 16'd10, 1'b0);
		send_pair(20'd256, 16'd20, 1'b0);
		send_pair(20'd512, 16'd30, 1'b1);
		send_pair(20'hFFF00, 16'd7, 1'b0);
		send_pair(20'd256, 16'd7, 1'b0);
		send_pair(20'd999, 16'd7, 1'b1);
		send_pair(20'd42, 16'd3, 1'b0);
		send_pair(20'd42, 16'd900, 1'b1);
		send_pair(20'd0, 16'd0, 1'b0);
		send_pair(20'd1, 16'hFFFF, 1'b1);
		drain_fits();
	endtask

	// Overfill a set so pairs beyond capacity are dropped, closing on a dropped pair
	task automatic test_capacity();
		int i;
		for (i = 0; i < lsq_pkg::MAX_SAMPLES + 3; i++) begin
			send_pair(lsq_pkg::X_W'($urandom), lsq_pkg::Y_W'($urandom),
				i == lsq_pkg::MAX_SAMPLES + 2);
		end
		send_set(lsq_pkg::MAX_SAMPLES, SHAPE_NOISE);
		for (i = 0; i < lsq_pkg::MAX_SAMPLES + 1; i++) begin
			send_pair(20'd5, 16'd9, i == lsq_pkg::MAX_SAMPLES);
		end
		drain_fits();
	endtask

	// Random sets, mostly short, under one idling mode
	task automatic test_random(input int pairs, input int idle_pct, input int stall_pct);
		int goal, len, roll;
		shape_t shape;
		send_idle_pct = idle_pct;
		recv_stall_pct = stall_pct;
		goal = sent_pairs + pairs;
		while (sent_pairs < goal) begin
			len = ($urandom_range(19) == 0) ? $urandom_range(70, 60) : $urandom_range(12, 1);
			roll = $urandom_range(9);
			if (roll < 3) begin
				shape = SHAPE_NOISE;
			end else if (roll < 8) begin
				shape = SHAPE_LINE;
			end else if (roll == 8) begin
				shape = SHAPE_FLAT_Y;
			end else begin
				shape = SHAPE_FLAT_X;
			end
			send_set(len, shape);
		end
		drain_fits();
	endtask

	// Block the result side for a long stretch while short sets keep coming
	task automatic test_backpressure();
		int i;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_cycles = 4000;
		for (i = 0; i < 20; i++) begin
			send_set(2, SHAPE_LINE);
		end
		drain_fits();
	endtask

	// Drive results out each cycle; stall at random or during a hold
	always @(negedge clk) begin
		if (hold_cycles > 0) begin
			hold_cycles <= hold_cycles - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// Compare each accepted result with the oldest prediction
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (pending_fits.size() == 0) begin
				$error("unexpected fit result");
				fail_count++;
			end else begin
				fit_t exp_fit;
				exp_fit = pending_fits.pop_front();
				fits_checked++;
				if (intercept !== exp_fit.intercept) begin
					$error("intercept: expected %h, got %h", exp_fit.intercept, intercept);
					fail_count++;
				end
				if (slope !== exp_fit.slope) begin
					$error("slope: expected %h, got %h", exp_fit.slope, slope);
					fail_count++;
				end
				if (r_squared !== exp_fit.r_squared) begin
					$error("r_squared: expected %0d, got %0d", exp_fit.r_squared, r_squared);
					fail_count++;
				end
				if (status !== exp_fit.status) begin
					$error("status: expected %0d, got %0d", exp_fit.status, status);
					fail_count++;
				end
				if (sample_count !== exp_fit.sample_count) begin
					$error("sample_count: expected %0d, got %0d", exp_fit.sample_count,
						sample_count);
					fail_count++;
				end
			end
		end
	end

	initial begin
		pair_n = 0;
		acc_x = 0;
		acc_y = 0;
		acc_x2 = 0;
		acc_xy = 0;
		acc_y2 = 0;
		dropped = 1'b0;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		test_directed();
		test_capacity();
		test_random(350, 0, 0);
		test_backpressure();
		test_random(300, 78, 0);
		test_random(300, 0, 78);
		test_random(350, 17, 17);
		repeat (600) @(posedge clk);
		$display("covered %0d pairs and checked %0d fits over four idling modes,",
			sent_pairs, fits_checked);
		$display("including capacity overflow, flat data, saturation and a long output hold");
		if (fail_count == 0 && pending_fits.size() == 0) begin
			$display("least_squares_line_fit_with_r_squared_core: match");
		end else begin
			$display("least_squares_line_fit_with_r_squared_core: mismatch");
		end
		$finish;
	end

	// Stop a hung run
	initial begin
		#60_000_000;
		$display("least_squares_line_fit_with_r_squared_core: mismatch");
		$finish;
	end

endmodule

/* least_squares_line_fit_with_r_squared_core.f */
rtl/lsq_pkg.sv
rtl/lsq_front.sv
rtl/lsq_queue.sv
rtl/lsq_arith.sv
rtl/lsq_back.sv
rtl/least_squares_line_fit_with_r_squared_core.sv
bench/least_squares_line_fit_with_r_squared_core_test.sv
